FILE: rtl/core/rilbp_pkg.sv
// Package for the rotation-invariant LBP code block.
// Window and result item types and the interpolation weights; no dependencies.
`timescale 1ns / 1ps

package rilbp_pkg;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned NUM_SAMP = 8;
    localparam int unsigned SAMP_W   = 20;
    localparam int unsigned TRANS_W  = 3;

    // Q0.12 bilinear weights for the diagonal samples at radius 1
    localparam logic [SAMP_W-1:0] W_CORNER = 20'd2048;
    localparam logic [SAMP_W-1:0] W_AXIAL  = 20'd848;
    localparam logic [SAMP_W-1:0] W_CENTER = 20'd352;
    localparam logic [SAMP_W-1:0] ONE_Q12  = 20'd4096;

    // Largest transition count still taken as uniform
    localparam logic [TRANS_W-1:0] MAX_UNIFORM_TRANS = 3'd2;

    typedef logic [PIX_W-1:0]    t_pix;
    typedef logic [NUM_SAMP-1:0] t_pattern;

    typedef struct packed {
        t_pix up_left;
        t_pix up;
        t_pix up_right;
        t_pix left;
        t_pix center_pixel;
        t_pix right;
        t_pix down_left;
        t_pix down;
        t_pix down_right;
    } t_win;

    typedef struct packed {
        logic [PIX_W-1:0]   pattern_code;
        logic [TRANS_W-1:0] transitions;
    } t_code;

endpackage

FILE: rtl/core/rotation_invariant_lbp_code.sv
// Rotation-invariant LBP code, 8 samples at radius 1 (top level).
// Uses rilbp_pkg, rilbp_diag_lane and rilbp_merge.
//
// Usage:
//   Input channel i_valid/o_ready carries one 3x3 window (i_win) per item.
//   Output channel o_valid/i_ready carries pattern_code and transitions.
//   i_cfg_we writes i_cfg_wdata into uniform_only; when set, items whose
//   pattern has more than two transitions produce no output item.
// Timing:
//   An item passes the pattern and then the output register. One item per
//   cycle is accepted when the output is not stalled: the compare pattern
//   register and the merge output register each hold one item.
//   The 8 sample compares run in parallel lanes in the first stage; the
//   rotation max tree and transition count run in the second.
// Reset:
//   Synchronous, active low: both stages empty, uniform_only cleared.
// Stall:
//   When i_ready is low the output item holds; the pipeline fills and
//   o_ready drops after two items are held.
`timescale 1ns / 1ps

module rotation_invariant_lbp_code
    import rilbp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_win  i_win,
    output logic  o_valid,
    input  logic  i_ready,
    output t_code o_code
);

    logic     r_uniform_only;
    logic     r_pat_vld;
    logic     n_pat_vld;
    t_pattern r_pat;
    t_pattern n_pat;
    t_pattern bits;
    logic     merge_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uniform_only <= 1'b0;
        end else if (i_cfg_we) begin
            r_uniform_only <= i_cfg_wdata;
        end
    end

    // Axial samples are the neighbor pixels
    assign bits[0] = i_win.right > i_win.center_pixel;
    assign bits[2] = i_win.up    > i_win.center_pixel;
    assign bits[4] = i_win.left  > i_win.center_pixel;
    assign bits[6] = i_win.down  > i_win.center_pixel;

    rilbp_diag_lane u_lane_ur (
        .i_corner (i_win.up_right),
        .i_side_a (i_win.up),
        .i_side_b (i_win.right),
        .i_center (i_win.center_pixel),
        .o_gt     (bits[1])
    );

    rilbp_diag_lane u_lane_ul (
        .i_corner (i_win.up_left),
        .i_side_a (i_win.up),
        .i_side_b (i_win.left),
        .i_center (i_win.center_pixel),
        .o_gt     (bits[3])
    );

    rilbp_diag_lane u_lane_dl (
        .i_corner (i_win.down_left),
        .i_side_a (i_win.left),
        .i_side_b (i_win.down),
        .i_center (i_win.center_pixel),
        .o_gt     (bits[5])
    );

    rilbp_diag_lane u_lane_dr (
        .i_corner (i_win.down_right),
        .i_side_a (i_win.down),
        .i_side_b (i_win.right),
        .i_center (i_win.center_pixel),
        .o_gt     (bits[7])
    );

    assign o_ready = !r_pat_vld || merge_ready;

    always_comb begin
        n_pat_vld = r_pat_vld;
        n_pat     = r_pat;
        if (o_ready) begin
            n_pat_vld = i_valid;
            n_pat     = bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_vld <= 1'b0;
        end else begin
            r_pat_vld <= n_pat_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat <= n_pat;
    end

    rilbp_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uniform_only (r_uniform_only),
        .i_valid        (r_pat_vld),
        .o_ready        (merge_ready),
        .i_pat          (r_pat),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_item         (o_code)
    );

endmodule

FILE: rtl/core/rilbp_diag_lane.sv
// One diagonal sample lane: bilinear Q0.12 sample compared against the center.
// Depends on rilbp_pkg.
`timescale 1ns / 1ps

module rilbp_diag_lane
    import rilbp_pkg::*;
(
    input  t_pix i_corner,
    input  t_pix i_side_a,
    input  t_pix i_side_b,
    input  t_pix i_center,
    output logic o_gt
);

    logic [SAMP_W-1:0] sample;
    logic [SAMP_W-1:0] ref_val;

    // Sum of weights is 4096, max sample 1044480 fits in 20 bits
    assign sample  = W_CORNER * SAMP_W'(i_corner)
                   + W_AXIAL  * (SAMP_W'(i_side_a) + SAMP_W'(i_side_b))
                   + W_CENTER * SAMP_W'(i_center);
    assign ref_val = ONE_Q12 * SAMP_W'(i_center);
    assign o_gt    = (sample > ref_val);

endmodule

FILE: rtl/core/rilbp_merge.sv
// Merge stage: rotation maximum, transition count, uniform filter, output register.
// Depends on rilbp_pkg.
`timescale 1ns / 1ps

module rilbp_merge
    import rilbp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_uniform_only,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_pattern i_pat,
    output logic     o_valid,
    input  logic     i_ready,
    output t_code    o_item
);

    logic                 r_vld;
    logic                 n_vld;
    t_code                r_item;
    t_code                n_item;
    logic [PIX_W-1:0]     rot   [NUM_SAMP];
    logic [PIX_W-1:0]     lvl1  [4];
    logic [PIX_W-1:0]     lvl2  [2];
    logic [PIX_W-1:0]     best;
    logic [NUM_SAMP-2:0]  diffs;
    logic [TRANS_W-1:0]   trans;
    logic                 drop;

    always_comb begin
        for (int i = 0; i < NUM_SAMP; i++) begin
            rot[i] = (i_pat << i) | (i_pat >> ((NUM_SAMP - i) % NUM_SAMP));
        end
        for (int i = 0; i < 4; i++) begin
            lvl1[i] = (rot[2*i] > rot[2*i+1]) ? rot[2*i] : rot[2*i+1];
        end
        for (int i = 0; i < 2; i++) begin
            lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
        end
        best = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
    end

    assign diffs = i_pat[NUM_SAMP-1:1] ^ i_pat[NUM_SAMP-2:0];
    assign trans = TRANS_W'($countones(diffs));
    assign drop  = i_uniform_only && (trans > MAX_UNIFORM_TRANS);

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        n_vld  = r_vld;
        n_item = r_item;
        if (o_ready) begin
            n_vld               = i_valid && !drop;
            n_item.pattern_code = best;
            n_item.transitions  = trans;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

`ifndef ASSERT_OFF
    a_code_msb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_item.pattern_code != '0) |-> r_item.pattern_code[PIX_W-1])
        else $error("nonzero code lacks top bit");

    a_flat_trans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && (r_item.pattern_code == '0 || r_item.pattern_code == '1))
        |-> r_item.transitions == '0)
        else $error("flat pattern with transitions");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !drop) |=> r_vld)
        else $error("kept item not emitted");
`endif

endmodule

FILE: verif/testbench.sv
// Testbench for rotation_invariant_lbp_code: directed window table, then random phases.
// Self-checking against an internal LBP code predictor; depends on rilbp_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import rilbp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES = 64;
    localparam int unsigned ITEMS_PER_PHASE = 76;
    localparam int unsigned NUM_PHASES = 7;

    typedef struct {
        t_win  win;
        bit    uni;
        bit    fixed;
        bit    emits;
        t_code code;
    } t_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_cfg_we = 1'b0;
    logic  i_cfg_wdata = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_win  i_win = '0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    t_code o_code;

    // side data that travels with the offered item
    bit    win_fixed = 1'b0;
    bit    win_emits = 1'b0;
    t_code win_code = '0;

    bit          uni_mode = 1'b0;
    int unsigned send_pct = 0;
    int unsigned rcv_pct = 0;
    int unsigned hold_left = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    t_code       code_queue[$];
    t_row        dir_rows[$];

    rotation_invariant_lbp_code i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_win      (i_win),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_code     (o_code)
    );

    always #6 i_clk = ~i_clk;

    function automatic int unsigned corner_sample(input t_pix corner, input t_pix a,
                                                  input t_pix b, input t_pix ctr);
        return int'(W_CORNER) * corner + int'(W_AXIAL) * (a + b) + int'(W_CENTER) * ctr;
    endfunction

    function automatic bit lbp_predict(input t_win w, input bit uni, output t_code res);
        int unsigned s[8];
        int unsigned ctr_ref;
        t_pattern    pat;
        t_pattern    best;
        logic [15:0] dbl;
        int unsigned trans;
        ctr_ref = int'(ONE_Q12) * w.center_pixel;
        s[0] = int'(ONE_Q12) * w.right;
        s[1] = corner_sample(w.up_right, w.up, w.right, w.center_pixel);
        s[2] = int'(ONE_Q12) * w.up;
        s[3] = corner_sample(w.up_left, w.up, w.left, w.center_pixel);
        s[4] = int'(ONE_Q12) * w.left;
        s[5] = corner_sample(w.down_left, w.left, w.down, w.center_pixel);
        s[6] = int'(ONE_Q12) * w.down;
        s[7] = corner_sample(w.down_right, w.down, w.right, w.center_pixel);
        pat = '0;
        for (int n = 0; n < 8; n++) pat[n] = (s[n] > ctr_ref);
        trans = 0;
        for (int n = 1; n < 8; n++) trans += pat[n] ^ pat[n-1];
        best = '0;
        dbl = {pat, pat};
        for (int i = 0; i < 8; i++) begin
            if (dbl[15-i -: 8] > best) best = dbl[15-i -: 8];
        end
        res.pattern_code = best;
        res.transitions = trans[2:0];
        return !(uni && trans > 2);
    endfunction

    function automatic t_win mk_win(input int ul, input int u, input int ur, input int l,
                                    input int c, input int r, input int dl, input int d,
                                    input int dr);
        t_win w;
        w.up_left = ul[7:0];
        w.up = u[7:0];
        w.up_right = ur[7:0];
        w.left = l[7:0];
        w.center_pixel = c[7:0];
        w.right = r[7:0];
        w.down_left = dl[7:0];
        w.down = d[7:0];
        w.down_right = dr[7:0];
        return w;
    endfunction

    function automatic t_win rand_win();
        int          px[9];
        int          samp_pos[8] = '{5, 2, 1, 0, 3, 6, 7, 8};
        int          kind;
        int          c;
        int          v;
        int unsigned run_len;
        int unsigned run_start;
        logic [7:0]  base;
        logic [15:0] dbl;
        t_pattern    mask;
        kind = $urandom_range(3);
        if (kind == 0) begin
            for (int k = 0; k < 9; k++) px[k] = $urandom_range(255);
        end else if (kind == 1) begin
            // pixels close to the center: equality and rounding edges
            c = $urandom_range(255);
            for (int k = 0; k < 9; k++) begin
                v = c + int'($urandom_range(6)) - 3;
                px[k] = (v < 0) ? 0 : (v > 255) ? 255 : v;
            end
            px[4] = c;
        end else begin
            // a run of bright neighbors, sometimes broken by one flipped sample
            c = $urandom_range(254, 1);
            run_len = $urandom_range(8);
            run_start = $urandom_range(7);
            base = 8'((16'h1 << run_len) - 1);
            dbl = {base, base} << run_start;
            mask = dbl[15:8];
            if ($urandom_range(9) == 0) mask[$urandom_range(7)] ^= 1'b1;
            for (int n = 0; n < 8; n++) begin
                if (mask[n]) px[samp_pos[n]] = $urandom_range(255, c + 1);
                else px[samp_pos[n]] = $urandom_range(c, 0);
            end
            px[4] = c;
        end
        return mk_win(px[0], px[1], px[2], px[3], px[4], px[5], px[6], px[7], px[8]);
    endfunction

    function automatic void add_row(input t_win w, input bit uni, input bit fixed,
                                    input bit emits, input int pc, input int tr);
        t_row row;
        row.win = w;
        row.uni = uni;
        row.fixed = fixed;
        row.emits = emits;
        row.code.pattern_code = pc[7:0];
        row.code.transitions = tr[2:0];
        dir_rows = {dir_rows, row};
    endfunction

    // call at a rising edge; returns at the edge where the item is accepted
    task automatic push_item(input t_win w, input bit fixed, input bit emits,
                             input t_code code);
        while ($urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_win <= w;
        win_fixed <= fixed;
        win_emits <= emits;
        win_code <= code;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_uniform(input bit v);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (code_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        uni_mode = v;
    endtask

    // output check, prediction at acceptance
    initial begin
        t_code exp_code;
        t_code pred;
        bit    emits;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (i_valid && o_ready) begin
                    if (win_fixed) begin
                        emits = win_emits;
                        pred = win_code;
                    end else begin
                        emits = lbp_predict(i_win, uni_mode, pred);
                    end
                    if (emits) code_queue = {code_queue, pred};
                end
                if (o_valid && i_ready) begin
                    if (code_queue.size() == 0) begin
                        $error("unexpected item: pattern_code %0h transitions %0d",
                               o_code.pattern_code, o_code.transitions);
                        err_count++;
                    end else begin
                        exp_code = code_queue.pop_front();
                        if (o_code.pattern_code !== exp_code.pattern_code) begin
                            $error("pattern_code expected %0h actual %0h",
                                   exp_code.pattern_code, o_code.pattern_code);
                            err_count++;
                        end
                        if (o_code.transitions !== exp_code.transitions) begin
                            $error("transitions expected %0d actual %0d",
                                   exp_code.transitions, o_code.transitions);
                            err_count++;
                        end
                    end
                end
            end
        end
    end

    // receiver: random ready, long hold counted down here
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** rotation_invariant_lbp_code: FAILED **");
            $finish;
        end
    end

    initial begin
        bit          ph_mode[NUM_PHASES] = '{0, 1, 0, 1, 0, 1, 0};
        int unsigned ph_send[NUM_PHASES] = '{0, 47, 0, 28, 47, 0, 28};
        int unsigned ph_rcv[NUM_PHASES] = '{0, 0, 47, 28, 0, 47, 28};
        bit          ph_hold[NUM_PHASES] = '{0, 0, 1, 0, 0, 1, 0};
        t_code       no_code;
        no_code = '0;

        add_row(mk_win(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 1, 1, 8'h00, 0);
        add_row(mk_win(255, 255, 255, 255, 255, 255, 255, 255, 255), 0, 1, 1, 8'h00, 0);
        add_row(mk_win(255, 255, 255, 255, 0, 255, 255, 255, 255), 0, 1, 1, 8'hff, 0);
        add_row(mk_win(0, 0, 0, 0, 255, 0, 0, 0, 0), 0, 1, 1, 8'h00, 0);
        add_row(mk_win(0, 0, 0, 0, 0, 1, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(mk_win(128, 128, 128, 128, 128, 129, 128, 128, 128), 0, 0, 0, 0, 0);
        add_row(mk_win(128, 128, 129, 128, 128, 128, 128, 128, 128), 0, 0, 0, 0, 0);
        add_row(mk_win(128, 129, 127, 128, 128, 129, 128, 128, 128), 0, 0, 0, 0, 0);
        add_row(mk_win(0, 101, 0, 101, 100, 101, 0, 101, 0), 0, 0, 0, 0, 0);
        add_row(mk_win(255, 200, 255, 200, 200, 200, 255, 200, 255), 0, 0, 0, 0, 0);
        add_row(mk_win(100, 0, 100, 200, 100, 200, 100, 0, 100), 0, 0, 0, 0, 0);
        add_row(mk_win(255, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(mk_win(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, 1, 8'h00, 0);
        add_row(mk_win(0, 101, 0, 101, 100, 101, 0, 101, 0), 1, 0, 0, 0, 0);
        add_row(mk_win(100, 0, 100, 200, 100, 200, 100, 0, 100), 1, 0, 0, 0, 0);
        add_row(mk_win(0, 0, 0, 0, 0, 1, 0, 0, 0), 1, 0, 0, 0, 0);
        add_row(mk_win(255, 255, 255, 255, 0, 255, 255, 255, 255), 1, 1, 1, 8'hff, 0);
        add_row(mk_win(128, 128, 129, 128, 128, 128, 128, 128, 128), 1, 0, 0, 0, 0);
        add_row(mk_win(255, 200, 255, 200, 200, 200, 255, 200, 255), 1, 0, 0, 0, 0);
        add_row(mk_win(254, 255, 254, 255, 254, 255, 254, 255, 254), 0, 0, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_uniform(1'b0);
        foreach (dir_rows[k]) begin
            if (dir_rows[k].uni != uni_mode) write_uniform(dir_rows[k].uni);
            push_item(dir_rows[k].win, dir_rows[k].fixed, dir_rows[k].emits,
                      dir_rows[k].code);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_pct = 0;
            write_uniform(ph_mode[p]);
            send_pct = ph_send[p];
            rcv_pct = ph_rcv[p];
            if (ph_hold[p]) hold_left = HOLD_CYCLES;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) push_item(rand_win(), 0, 0, no_code);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (code_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("** rotation_invariant_lbp_code: PASSED **");
        end else begin
            $display("** rotation_invariant_lbp_code: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rilbp_pkg.sv
rtl/core/rilbp_diag_lane.sv
rtl/core/rilbp_merge.sv
rtl/core/rotation_invariant_lbp_code.sv
verif/testbench.sv
